// ----- rtl/sdcr_pkg.sv -----
// Shared constants, types and the checksum mix function for the
// step/direction counter reporter. No dependencies.
package sdcr_pkg;

   // Channel count default and fixed field widths
   localparam int NUM_CHANNELS_DEF = 6;
   localparam int PIN_W            = 6;
   localparam int WORD_W           = 16;
   localparam int BYTE_W           = 8;

   // Request action codes
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_REPORT = 1'b1;

   // Frame and checksum constants
   localparam logic [BYTE_W-1:0] FRAME_SYNC = 8'hED;
   localparam logic [WORD_W-1:0] CK_SEED    = 16'hBAD1;
   localparam logic [WORD_W-1:0] CK_MUL     = 16'h6967;
   localparam logic [WORD_W-1:0] CK_ADD     = 16'h1551;

   // Control for one counter lane
   typedef struct packed {
      logic en;
      logic step;
      logic dir;
   } lane_ctl_type;

   // Fold one word into the running checksum, modulo 2^16
   function automatic logic [WORD_W-1:0] ck_mix(input logic [WORD_W-1:0] sum,
                                                input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0]   t;
      logic [2*WORD_W-1:0] p;
      t = sum + word;
      p = t * CK_MUL;
      return p[WORD_W-1:0] + CK_ADD;
   endfunction

endpackage

// ----- rtl/sdcr_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
// Depends on sdcr_pkg.
interface sdcr_req_if;
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic [sdcr_pkg::PIN_W-1:0] step_pins;
   logic [sdcr_pkg::PIN_W-1:0] dir_pins;

   modport source (output valid, action, step_pins, dir_pins, input ready);
   modport sink   (input valid, action, step_pins, dir_pins, output ready);
endinterface

interface sdcr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sdcr_pkg::BYTE_W-1:0] frame_byte;
   logic                        frame_last;

   modport source (output valid, frame_byte, frame_last, input ready);
   modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

// ----- rtl/sdcr_lane.sv -----
// One step/direction channel: step edge detect and 16-bit position counter.
// Depends on sdcr_pkg.
module sdcr_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  sdcr_pkg::lane_ctl_type       ctl,
   output logic [sdcr_pkg::WORD_W-1:0]  count
);

   logic                        prev_ff, prev_in;
   logic [sdcr_pkg::WORD_W-1:0] count_ff, count_in;
   logic                        rising;

   // Detect a rising step edge against the last sampled level
   assign rising = ctl.en && ctl.step && !prev_ff;

   // Advance the counter up or down on each edge, hold the level on each sample
   always_comb begin
      prev_in  = prev_ff;
      count_in = count_ff;
      if (ctl.en) begin
         prev_in = ctl.step;
      end
      if (rising) begin
         if (ctl.dir) begin
            count_in = count_ff + 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// ----- rtl/sdcr_framer.sv -----
// Merge stage: snapshots all lane counters and sends them as a checksummed
// byte frame, one byte per response word. Depends on sdcr_pkg, sdcr_if.
module sdcr_framer #(
   parameter int NUM_CHANNELS = sdcr_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic [NUM_CHANNELS-1:0][sdcr_pkg::WORD_W-1:0] counts,
   output logic                                          busy,
   sdcr_rsp_if.source                                    rsp
);

   localparam int FRAME_BYTES = 2 * NUM_CHANNELS + 4;
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int WIDX_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [sdcr_pkg::BYTE_W-1:0] PAY_LEN = sdcr_pkg::BYTE_W'(2 * NUM_CHANNELS + 2);
   localparam logic [sdcr_pkg::WORD_W-1:0] HDR_SUM =
      sdcr_pkg::ck_mix(sdcr_pkg::CK_SEED, {PAY_LEN, sdcr_pkg::FRAME_SYNC});
   localparam logic [IDX_W-1:0] IDX_LEN     = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_FIRST_H = IDX_W'(3);
   localparam logic [IDX_W-1:0] IDX_LAST_H  = IDX_W'(FRAME_BYTES - 3);
   localparam logic [IDX_W-1:0] IDX_CK_LO   = IDX_W'(FRAME_BYTES - 2);
   localparam logic [IDX_W-1:0] IDX_CK_HI   = IDX_W'(FRAME_BYTES - 1);

   logic                                          busy_ff, busy_in;
   logic [IDX_W-1:0]                              idx_ff, idx_in;
   logic [sdcr_pkg::WORD_W-1:0]                   sum_ff, sum_in;
   logic [NUM_CHANNELS-1:0][sdcr_pkg::WORD_W-1:0] words_ff, words_in;

   logic [IDX_W-1:0]            off;
   logic [WIDX_W-1:0]           widx;
   logic [sdcr_pkg::WORD_W-1:0] cur_word;
   logic                        fire;
   logic                        is_last;

   // Select the counter word that the current byte belongs to
   assign off      = idx_ff - IDX_W'(2);
   assign widx     = WIDX_W'(off >> 1);
   assign cur_word = (widx < NUM_CHANNELS) ? words_ff[widx] : '0;
   assign is_last  = (idx_ff == IDX_CK_HI);
   assign fire     = busy_ff && rsp.ready;

   // Pick the byte in send order
   always_comb begin
      if (idx_ff == '0) begin
         rsp.frame_byte = sdcr_pkg::FRAME_SYNC;
      end else if (idx_ff == IDX_LEN) begin
         rsp.frame_byte = PAY_LEN;
      end else if (idx_ff == IDX_CK_LO) begin
         rsp.frame_byte = sum_ff[7:0];
      end else if (idx_ff == IDX_CK_HI) begin
         rsp.frame_byte = sum_ff[15:8];
      end else if (idx_ff[0]) begin
         rsp.frame_byte = cur_word[15:8];
      end else begin
         rsp.frame_byte = cur_word[7:0];
      end
   end

   assign rsp.valid      = busy_ff;
   assign rsp.frame_last = is_last;
   assign busy           = busy_ff;

   // Load the snapshot on start, advance one byte per taken word, fold each
   // counter into the checksum as its high byte goes out
   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      words_in = words_ff;
      if (start) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         sum_in   = HDR_SUM;
         words_in = counts;
      end else if (fire) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
         if (idx_ff[0] && idx_ff >= IDX_FIRST_H && idx_ff <= IDX_LAST_H) begin
            sum_in = sdcr_pkg::ck_mix(sum_ff, cur_word);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      words_ff <= words_in;
   end

   // Frame ends exactly after its last byte is taken
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (fire && is_last && !start) |=> !busy_ff)
      else $error("framer still busy after last byte");

   // A start opens a frame at the sync byte
   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && idx_ff == '0))
      else $error("frame did not open at sync byte");

   // A start is only issued while idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("report started during a frame");

   // A stalled byte keeps its position and checksum
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !rsp.ready) |=> ($stable(idx_ff) && $stable(sum_ff)))
      else $error("frame position moved while stalled");

endmodule

// ----- rtl/step_dir_counter_reporter.sv -----
// Step/direction position counter with framed byte report.
// Timing: a sample updates its counters at the edge that accepts it; a report
// shows its first byte in the cycle after acceptance.
// Throughput: one sample per cycle at all times, also while a frame is sent;
// a report sends 2*NUM_CHANNELS+4 bytes (16 at six channels), one byte per
// taken response word, and a further report waits until the last byte is taken.
// Reset (synchronous): counters and step levels clear to zero, framer idles.
module step_dir_counter_reporter #(
   parameter int NUM_CHANNELS = sdcr_pkg::NUM_CHANNELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sdcr_req_if.sink   req,
   sdcr_rsp_if.source rsp
);

   logic                                          accept;
   logic                                          sample_en;
   logic                                          start;
   logic                                          busy;
   logic [NUM_CHANNELS-1:0][sdcr_pkg::WORD_W-1:0] counts;

   // Take samples always; hold reports while a frame is in flight
   assign req.ready = !busy || (req.action != sdcr_pkg::ACT_REPORT);
   assign accept    = req.valid && req.ready;
   assign sample_en = accept && (req.action == sdcr_pkg::ACT_SAMPLE);
   assign start     = accept && (req.action == sdcr_pkg::ACT_REPORT);

   // One counter lane per channel
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
      sdcr_pkg::lane_ctl_type ctl;
      assign ctl.en   = sample_en;
      assign ctl.step = req.step_pins[i];
      assign ctl.dir  = req.dir_pins[i];

      sdcr_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .count (counts[i])
      );
   end

   // Merge the lanes into one report frame
   sdcr_framer #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_framer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .counts (counts),
      .busy   (busy),
      .rsp    (rsp)
   );

endmodule

// ----- sim/step_dir_counter_reporter_test.sv -----
// Self-checking bench for step_dir_counter_reporter: random step/dir samples and
// report requests, each frame checked byte by byte against a local position model.
// Depends on sdcr_pkg, sdcr_if and the step_dir_counter_reporter RTL.
module step_dir_counter_reporter_test;

   localparam int   BYTE_W       = sdcr_pkg::BYTE_W;
   localparam int   WORD_W       = sdcr_pkg::WORD_W;
   localparam int   PIN_W        = sdcr_pkg::PIN_W;
   localparam logic ACT_SAMPLE   = sdcr_pkg::ACT_SAMPLE;
   localparam logic ACT_REPORT   = sdcr_pkg::ACT_REPORT;
   localparam int   NCH          = sdcr_pkg::NUM_CHANNELS_DEF;
   localparam int   FRAME_LEN    = 2*NCH + 4;
   localparam int   QUIET_LIMIT  = 1000;
   localparam int   DRAIN_CYCLES = 2*FRAME_LEN;
   localparam int   PHASE_COUNT  = 8;
   localparam int   PHASE_WORDS  = 46;

   // Position model: counters, last step levels and the frame bytes still owed
   class frame_tracker;
      typedef struct packed {
         logic [BYTE_W-1:0] data;
         logic              last;
      } frame_beat_type;

      logic [WORD_W-1:0] positions [NCH];
      logic [NCH-1:0]    last_steps;
      frame_beat_type    bytes_due [$];
      int                errors;

      function new();
         foreach (positions[i]) positions[i] = '0;
         last_steps = '0;
         errors     = 0;
      endfunction

      function logic [WORD_W-1:0] fold_word(input logic [WORD_W-1:0] sum,
                                            input logic [WORD_W-1:0] word);
         return WORD_W'((32'(sum) + 32'(word)) * 32'(sdcr_pkg::CK_MUL)
                        + 32'(sdcr_pkg::CK_ADD));
      endfunction

      function void add_byte(input logic [BYTE_W-1:0] data, input logic last);
         frame_beat_type beat;
         beat.data = data;
         beat.last = last;
         bytes_due.push_back(beat);
      endfunction

      // Apply one accepted request word
      function void note_word(input logic act, input logic [PIN_W-1:0] steps,
                              input logic [PIN_W-1:0] dirs);
         logic [NCH-1:0]    rise;
         logic [WORD_W-1:0] sum;
         logic [BYTE_W-1:0] plen;
         if (act == ACT_SAMPLE) begin
            // count rising step edges, up or down by the direction level
            rise = steps[NCH-1:0] & ~last_steps;
            for (int i = 0; i < NCH; i++) begin
               if (rise[i])
                  positions[i] = dirs[i] ? positions[i] + 16'd1 : positions[i] - 16'd1;
            end
            last_steps = steps[NCH-1:0];
         end else begin
            // snapshot the counters into a frame; pins are ignored
            plen = BYTE_W'(2*NCH + 2);
            sum  = fold_word(sdcr_pkg::CK_SEED, {plen, sdcr_pkg::FRAME_SYNC});
            add_byte(sdcr_pkg::FRAME_SYNC, 1'b0);
            add_byte(plen, 1'b0);
            for (int i = 0; i < NCH; i++) begin
               add_byte(positions[i][7:0], 1'b0);
               add_byte(positions[i][15:8], 1'b0);
               sum = fold_word(sum, positions[i]);
            end
            add_byte(sum[7:0], 1'b0);
            add_byte(sum[15:8], 1'b1);
         end
      endfunction

      // Compare one taken response word with the oldest owed byte
      function void check_byte(input logic [BYTE_W-1:0] got_data, input logic got_last);
         frame_beat_type want;
         if (bytes_due.size() == 0) begin
            $display("%0t: unexpected frame byte %02h last %0b", $time, got_data, got_last);
            errors++;
            return;
         end
         want = bytes_due.pop_front();
         if (got_data !== want.data) begin
            $display("%0t: frame_byte expected %02h actual %02h", $time, want.data, got_data);
            errors++;
         end
         if (got_last !== want.last) begin
            $display("%0t: frame_last expected %0b actual %0b", $time, want.last, got_last);
            errors++;
         end
      endfunction

      function int pending();
         return bytes_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   quiet_cycles;
   frame_tracker tracker;

   sdcr_req_if req ();
   sdcr_rsp_if rsp ();

   step_dir_counter_reporter i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stall the response side at random
   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Check taken bytes and watch for a hung channel
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready)
            tracker.check_byte(rsp.frame_byte, rsp.frame_last);
         if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Offer one request word, with random idle cycles ahead of it
   task automatic drive_word(input logic act, input logic [PIN_W-1:0] steps,
                             input logic [PIN_W-1:0] dirs);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.action    <= act;
      req.step_pins <= steps;
      req.dir_pins  <= dirs;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      tracker.note_word(act, steps, dirs);
   endtask

   // Hold off until every owed byte has arrived, then let the block settle
   task automatic drain_frames();
      req.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
         default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
   endtask

   initial begin
      logic [PIN_W-1:0] steps;
      tracker        = new();
      quiet_cycles   = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.action     = ACT_SAMPLE;
      req.step_pins  = '0;
      req.dir_pins   = '0;
      rsp.ready      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero frame, held and falling steps, wrap both ways
      drive_word(ACT_REPORT, 6'h00, 6'h00);
      drive_word(ACT_SAMPLE, 6'h00, 6'h00);
      drive_word(ACT_SAMPLE, 6'h3F, 6'h3F);
      drive_word(ACT_SAMPLE, 6'h3F, 6'h00);
      drive_word(ACT_SAMPLE, 6'h00, 6'h00);
      drive_word(ACT_SAMPLE, 6'h3F, 6'h00);
      drive_word(ACT_SAMPLE, 6'h00, 6'h3F);
      drive_word(ACT_SAMPLE, 6'h3F, 6'h00);
      drive_word(ACT_REPORT, 6'h00, 6'h00);
      drive_word(ACT_SAMPLE, 6'h00, 6'h3F);
      drive_word(ACT_SAMPLE, 6'h3F, 6'h3F);
      drive_word(ACT_SAMPLE, 6'h15, 6'h3F);
      drive_word(ACT_SAMPLE, 6'h2A, 6'h2A);
      // report pins must not be taken as a sample
      drive_word(ACT_REPORT, 6'h3F, 6'h3F);
      drive_word(ACT_SAMPLE, 6'h3F, 6'h00);
      drive_word(ACT_REPORT, 6'h00, 6'h00);
      // samples while a frame is still going out, then back-to-back reports
      drive_word(ACT_SAMPLE, 6'h00, 6'h15);
      drive_word(ACT_SAMPLE, 6'h3F, 6'h15);
      drive_word(ACT_REPORT, 6'h2A, 6'h15);
      drive_word(ACT_REPORT, 6'h15, 6'h2A);
      drain_frames();

      // Random: mostly samples, occasional reports, idling varied by phase
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         set_idling(phase % 4);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            steps = ($urandom_range(0, 3) == 0) ? '0 : PIN_W'($urandom_range(0, 63));
            if ($urandom_range(0, 9) == 0)
               drive_word(ACT_REPORT, PIN_W'($urandom_range(0, 63)),
                          PIN_W'($urandom_range(0, 63)));
            else
               drive_word(ACT_SAMPLE, steps, PIN_W'($urandom_range(0, 63)));
         end
         drive_word(ACT_REPORT, '0, '0);
         drain_frames();
      end

      if (tracker.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
